// ===== hdl/gf2tm_pkg.sv =====
// ----------------------------------------------------------------------------
// gf2tm_pkg
// Shared widths, register map and helpers for the GF(2^n) trinomial multiplier.
// ----------------------------------------------------------------------------
package gf2tm_pkg;

  // operand and product widths
  localparam int OPERAND_W = 32;
  localparam int PROD_W    = 2 * OPERAND_W - 1;
  localparam int LANE_W    = 8;
  localparam int LANES     = OPERAND_W / LANE_W;
  localparam int PART_W    = OPERAND_W + LANE_W - 1;

  // field degree register
  localparam int                 DEGREE_W        = 6;
  localparam logic [DEGREE_W-1:0] DEGREE_RESET   = DEGREE_W'(32);
  localparam logic [DEGREE_W-1:0] DEGREE_MIN     = DEGREE_W'(2);
  localparam int                 MAX_DEGREE_DEF  = 32;
  localparam int                 DEGREE_CEIL     = 63;

  // configuration port
  localparam int               DATA_W           = 32;
  localparam int               PADDR_W          = 3;
  localparam logic [0:0]       REG_FIELD_DEGREE = 1'b0;

  // control that travels with each item down the pipeline
  typedef struct packed {
    logic                valid;
    logic [DEGREE_W-1:0] degree;
  } stage_ctrl_t;

  // ones below the field degree, over the operand width
  function automatic logic [OPERAND_W-1:0] degree_mask(input logic [DEGREE_W-1:0] degree);
    logic [OPERAND_W-1:0] mask;
    for (int i = 0; i < OPERAND_W; i++) begin
      mask[i] = (DEGREE_W'(i) < degree);
    end
    return mask;
  endfunction

endpackage

// ===== hdl/gf2tm_clmul.sv =====
// ----------------------------------------------------------------------------
// gf2tm_clmul
// Two-stage carry-less multiplier: byte-lane partial products, then combine.
// ----------------------------------------------------------------------------
module gf2tm_clmul (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  gf2tm_pkg::stage_ctrl_t         ctrl_i,
  input  logic [gf2tm_pkg::OPERAND_W-1:0] a_i,
  input  logic [gf2tm_pkg::OPERAND_W-1:0] b_i,
  output gf2tm_pkg::stage_ctrl_t         ctrl_o,
  output logic [gf2tm_pkg::PROD_W-1:0]    prod_o
);
  import gf2tm_pkg::*;

  stage_ctrl_t              part_ctrl_q;
  logic [PART_W-1:0]        part_d [LANES];
  logic [PART_W-1:0]        part_q [LANES];
  stage_ctrl_t              prod_ctrl_q;
  logic [PROD_W-1:0]        prod_d;
  logic [PROD_W-1:0]        prod_q;

  // partial product per byte lane of b
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      part_d[k] = '0;
      for (int j = 0; j < LANE_W; j++) begin
        if (b_i[k*LANE_W + j]) begin
          part_d[k] = part_d[k] ^ (PART_W'(a_i) << j);
        end
      end
    end
  end

  // fold the lanes into the full product
  always_comb begin
    prod_d = '0;
    for (int k = 0; k < LANES; k++) begin
      prod_d = prod_d ^ (PROD_W'(part_q[k]) << (k * LANE_W));
    end
  end

  // item control bits: valid and degree
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_ctrl_q <= '0;
      prod_ctrl_q <= '0;
    end else begin
      part_ctrl_q <= ctrl_i;
      prod_ctrl_q <= part_ctrl_q;
    end
  end

  // payload stages
  always_ff @(posedge clk_i) begin
    part_q <= part_d;
    prod_q <= prod_d;
  end

  assign ctrl_o = prod_ctrl_q;
  assign prod_o = prod_q;

endmodule

// ===== hdl/gf2n_trinomial_multiplier_unit.sv =====
// ----------------------------------------------------------------------------
// gf2n_trinomial_multiplier_unit
// GF(2^n) multiplier reducing modulo x^n + x + 1, n set over an APB port.
// ----------------------------------------------------------------------------
// One item is taken in every clock cycle; busy stays low. Each result appears
// on product_o with result_valid_o once its item has passed the four register
// stages: operand masking, byte-lane partial products, lane combine, trinomial
// reduction. The receiver cannot stall, so results leave in order, one per
// cycle. field_degree below 2 acts as 2 and above MAX_DEGREE (capped at 63) as
// that maximum; each item uses the degree in force when it is taken. Change the
// degree only while no item is in flight.
module gf2n_trinomial_multiplier_unit #(
  parameter int MAX_DEGREE = gf2tm_pkg::MAX_DEGREE_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // item channel
  input  logic                             start,
  output logic                             busy,
  input  logic [gf2tm_pkg::OPERAND_W-1:0]  operand_a_i,
  input  logic [gf2tm_pkg::OPERAND_W-1:0]  operand_b_i,
  output logic                             result_valid_o,
  output logic [gf2tm_pkg::OPERAND_W-1:0]  product_o,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [gf2tm_pkg::PADDR_W-1:0]    paddr,
  input  logic [gf2tm_pkg::DATA_W-1:0]     pwdata,
  output logic [gf2tm_pkg::DATA_W-1:0]     prdata,
  output logic                             pready
);
  import gf2tm_pkg::*;

  localparam int EFF_MAX = (MAX_DEGREE > DEGREE_CEIL) ? DEGREE_CEIL : MAX_DEGREE;
  localparam logic [DEGREE_W-1:0] DEGREE_MAX = DEGREE_W'(EFF_MAX);

  logic                  cfg_sel;
  logic                  cfg_write;
  logic [DEGREE_W-1:0]   degree_q;
  logic [DEGREE_W-1:0]   degree_eff;
  logic [OPERAND_W-1:0]  op_mask;
  stage_ctrl_t           in_ctrl_q;
  logic [OPERAND_W-1:0]  a_q;
  logic [OPERAND_W-1:0]  b_q;
  stage_ctrl_t           mul_ctrl;
  logic [PROD_W-1:0]     mul_prod;
  logic [PROD_W-1:0]     high_part;
  logic [OPERAND_W-1:0]  product_d;
  logic                  result_valid_q;
  logic [OPERAND_W-1:0]  product_q;

  // register decode
  assign cfg_sel   = (paddr[PADDR_W-1:2] == REG_FIELD_DEGREE);
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = cfg_sel ? DATA_W'(degree_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q <= DEGREE_RESET;
    end else if (cfg_write && cfg_sel) begin
      degree_q <= pwdata[DEGREE_W-1:0];
    end
  end

  // clamp the degree into the supported range
  always_comb begin
    degree_eff = degree_q;
    if (degree_q < DEGREE_MIN) begin
      degree_eff = DEGREE_MIN;
    end else if (degree_q > DEGREE_MAX) begin
      degree_eff = DEGREE_MAX;
    end
  end

  assign busy    = 1'b0;
  assign op_mask = degree_mask(degree_eff);

  // stage 0: capture masked operands
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ctrl_q <= '0;
    end else begin
      in_ctrl_q.valid  <= start && !busy;
      in_ctrl_q.degree <= degree_eff;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= operand_a_i & op_mask;
    b_q <= operand_b_i & op_mask;
  end

  // stages 1 and 2: carry-less product
  gf2tm_clmul u_clmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (in_ctrl_q),
    .a_i    (a_q),
    .b_i    (b_q),
    .ctrl_o (mul_ctrl),
    .prod_o (mul_prod)
  );

  // stage 3: fold x^i for i >= n onto x^(i-n+1) + x^(i-n)
  assign high_part = mul_prod >> mul_ctrl.degree;
  assign product_d = (mul_prod[OPERAND_W-1:0] ^ high_part[OPERAND_W-1:0]
                      ^ {high_part[OPERAND_W-2:0], 1'b0})
                     & degree_mask(mul_ctrl.degree);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= mul_ctrl.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    product_q <= product_d;
  end

  assign result_valid_o = result_valid_q;
  assign product_o      = product_q;

  // every taken item comes out on result_valid_o
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##4 result_valid_o)
    else $error("item lost in pipeline");

  // clamped degree stays inside the legal range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (degree_eff >= DEGREE_MIN) && (degree_eff <= DEGREE_MAX))
    else $error("effective degree out of range");

  // a degree write lands in the register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_write && cfg_sel) |=> (degree_q == $past(pwdata[DEGREE_W-1:0])))
    else $error("degree write not taken");

  // reduced product has no terms at or above the degree
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ((product_o & ~degree_mask($past(mul_ctrl.degree))) == '0))
    else $error("product not fully reduced");

endmodule
